// ===== sv/cddstg_pkg.sv =====
// Shared types and constants for the cadenced DDS tone generator.
// Holds the cadence phase codes, register indexes, reset values and the sine ROM.
// Used by cddstg_core, cddstg_skid and cadenced_dds_tone_generator_top.
package cddstg_pkg;

  localparam int TUNING_BITS = 32;
  localparam int LEN_BITS    = 25;
  localparam int CNT_BITS    = 24;
  localparam int SAMPLE_BITS = 8;
  localparam int ROM_BITS    = 8;
  localparam int ROM_SIZE    = 256;
  localparam int INDEX_BITS  = 2;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_TUNING_WORD = 2'd0,
    REG_PULSE_TICKS = 2'd1,
    REG_PAUSE_TICKS = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_TONE_START = 2'd0,
    PH_TONE_ON    = 2'd1,
    PH_SIL_START  = 2'd2,
    PH_SILENCE    = 2'd3
  } cadence_phase_t;

  localparam logic [TUNING_BITS-1:0] TUNING_RESET = 32'd58175761;
  localparam logic [LEN_BITS-1:0]    LEN_RESET    = '1;

  typedef struct packed {
    logic        [TUNING_BITS-1:0] tuning_word;
    logic signed [LEN_BITS-1:0]    pulse_ticks;
    logic signed [LEN_BITS-1:0]    pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   tone_on;
  } result_t;

  localparam logic [SAMPLE_BITS-1:0] SINE_ROM [ROM_SIZE] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd178, 8'd181, 8'd184, 8'd187, 8'd190, 8'd192, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd212, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231,
    8'd233, 8'd234, 8'd236, 8'd238, 8'd239, 8'd240, 8'd242, 8'd243,
    8'd244, 8'd245, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250, 8'd251,
    8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253, 8'd252,
    8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd248, 8'd247, 8'd245,
    8'd244, 8'd243, 8'd242, 8'd240, 8'd239, 8'd238, 8'd236, 8'd234,
    8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd212, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd192, 8'd190, 8'd187, 8'd184, 8'd181, 8'd178,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd12,  8'd11,
    8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

// ===== sv/cddstg_core.sv =====
// Cadence sequencer, phase accumulator and sine lookup of the tone generator.
// Updates its state once per accepted word and presents the new result.
// Depends on cddstg_pkg.
module cddstg_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int PHASE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  tick,
  input  cddstg_pkg::cfg_t      cfg,
  output cddstg_pkg::result_t   result
);

  localparam int STEP_BITS = $clog2(TABLE_DEPTH);

  cddstg_pkg::cadence_phase_t          phase, phase_next;
  logic [cddstg_pkg::CNT_BITS-1:0]     remaining, remaining_next;
  logic [PHASE_BITS-1:0]               acc, acc_next;
  logic                                running, running_next;
  logic [cddstg_pkg::SAMPLE_BITS-1:0]  last_sample, last_sample_next;

  logic [PHASE_BITS+cddstg_pkg::TUNING_BITS-1:0] tuning_ext;
  logic [PHASE_BITS-1:0]                         acc_sum;
  logic [STEP_BITS-1:0]                          table_step;
  logic [STEP_BITS+cddstg_pkg::ROM_BITS-1:0]     step_scaled;
  logic [cddstg_pkg::ROM_BITS-1:0]               rom_index;

  always_comb begin
    tuning_ext  = {{PHASE_BITS{1'b0}}, cfg.tuning_word};
    acc_sum     = acc + tuning_ext[PHASE_BITS-1:0];
    table_step  = acc_sum[PHASE_BITS-1 -: STEP_BITS];
    step_scaled = {table_step, {cddstg_pkg::ROM_BITS{1'b0}}};
    rom_index   = step_scaled[STEP_BITS +: cddstg_pkg::ROM_BITS];
  end

  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    running_next     = running;
    acc_next         = acc;
    last_sample_next = last_sample;
    if (tick) begin
      case (phase)
        cddstg_pkg::PH_TONE_START: begin
          running_next = 1'b1;
          if (!cfg.pulse_ticks[cddstg_pkg::LEN_BITS-1]) begin
            remaining_next = cfg.pulse_ticks[cddstg_pkg::CNT_BITS-1:0];
            phase_next     = cddstg_pkg::PH_TONE_ON;
          end
        end
        cddstg_pkg::PH_TONE_ON: begin
          if (remaining == '0) begin
            phase_next = cddstg_pkg::PH_SIL_START;
          end else begin
            remaining_next = remaining - 1'b1;
          end
        end
        cddstg_pkg::PH_SIL_START: begin
          running_next = 1'b0;
          if (!cfg.pause_ticks[cddstg_pkg::LEN_BITS-1]) begin
            remaining_next = cfg.pause_ticks[cddstg_pkg::CNT_BITS-1:0];
            phase_next     = cddstg_pkg::PH_SILENCE;
          end
        end
        default: begin
          if (remaining == '0) begin
            phase_next = cddstg_pkg::PH_TONE_START;
          end else begin
            remaining_next = remaining - 1'b1;
          end
        end
      endcase
      if (running_next) begin
        acc_next         = acc_sum;
        last_sample_next = cddstg_pkg::SINE_ROM[rom_index];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cddstg_pkg::PH_TONE_START;
      remaining   <= '0;
      acc         <= '0;
      running     <= 1'b0;
      last_sample <= '0;
    end else if (step) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      acc         <= acc_next;
      running     <= running_next;
      last_sample <= last_sample_next;
    end
  end

  always_comb begin
    result.sample  = last_sample_next;
    result.tone_on = running_next;
  end

endmodule

// ===== sv/cddstg_skid.sv =====
// Output register with one skid stage for the tone generator results.
// Lets a new word enter while a finished word waits on a stalled output.
// Depends on cddstg_pkg.
module cddstg_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cddstg_pkg::result_t  push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cddstg_pkg::result_t  out_data
);

  logic                skid_valid;
  cddstg_pkg::result_t skid_data;
  logic                pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/cadenced_dds_tone_generator_top.sv =====
// Each input word, a sample tick when tick is high, yields exactly one result word: the
// sine sample and the tone-on flag after that word. A word is taken each cycle that
// in_stall is low; cadence step, phase add and sine ROM read happen in the same cycle,
// and the result lands in an output register backed by one skid stage, so input stall
// rises only when two results wait. The user must write registers through wr_en,
// wr_index and wr_data only while no word is in flight; the block does not enforce it.
module cadenced_dds_tone_generator_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int PHASE_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [cddstg_pkg::INDEX_BITS-1:0]    wr_index,
  input  logic [cddstg_pkg::TUNING_BITS-1:0]   wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cddstg_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                 tone_on
);

  cddstg_pkg::cfg_t    cfg;
  cddstg_pkg::result_t core_result;
  cddstg_pkg::result_t out_data;
  logic                accept;
  logic                full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tuning_word <= cddstg_pkg::TUNING_RESET;
      cfg.pulse_ticks <= cddstg_pkg::LEN_RESET;
      cfg.pause_ticks <= cddstg_pkg::LEN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        cddstg_pkg::REG_TUNING_WORD: cfg.tuning_word <= wr_data;
        cddstg_pkg::REG_PULSE_TICKS: cfg.pulse_ticks <= wr_data[cddstg_pkg::LEN_BITS-1:0];
        cddstg_pkg::REG_PAUSE_TICKS: cfg.pause_ticks <= wr_data[cddstg_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  cddstg_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .tick   (tick),
    .cfg    (cfg),
    .result (core_result)
  );

  cddstg_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign sample  = out_data.sample;
  assign tone_on = out_data.tone_on;

endmodule
